// ===== rtl/core/first_fit_block_allocator_assert.svh =====
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_ASSERT_SVH

// same-cycle implication
`define FFBA_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define FFBA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/ffba_pkg.sv =====
package ffba_pkg;

	localparam int MAX_BLOCKS   = 64;
	localparam int HEADER_BYTES = 24;
	localparam int SIZE_BITS    = 24;
	localparam int IDX_W        = $clog2(MAX_BLOCKS);
	localparam int LINK_W       = IDX_W + 1;
	localparam int HANDLE_W     = 6;
	localparam int CFG_ADDR_W   = 3;

	typedef enum logic [1:0] {
		FN_ALLOC  = 2'd0,
		FN_FREE   = 2'd1,
		FN_RESIZE = 2'd2,
		FN_NOP    = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_NULL = 2'd1,
		ST_FAIL = 2'd2
	} status_t;

	localparam logic CFG_HEAP_LIMIT = 1'b0;

	typedef struct packed {
		logic [SIZE_BITS-1:0] bytes;
		logic [SIZE_BITS-1:0] start;
		logic [LINK_W-1:0]    link;
		logic                 free;
	} rec_t;

	localparam int REC_W = $bits(rec_t);

	typedef enum logic [4:0] {
		S_IDLE, S_DISP, S_KRD, S_KCHK, S_ATEST, S_AEVAL, S_GROW, S_GLINK,
		S_RRD, S_RMARK, S_RNRD, S_RNCHK, S_WTEST, S_WEVAL, S_WNEVAL, S_EMIT
	} state_t;

	typedef enum logic [4:0] {
		OP_NONE, OP_LOAD, OP_INIT, OP_KRD, OP_KCHK, OP_ATEST, OP_AEVAL, OP_GROW,
		OP_GLINK, OP_RRD, OP_RMARK, OP_RNRD, OP_RNCHK, OP_WTEST, OP_WEVAL,
		OP_WNEVAL, OP_EMIT
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
		logic   in_ready;
	} dp_cmd_t;

	typedef struct packed {
		func_t func;
		logic  has;
		logic  h_valid;
		logic  size_zero;
		logic  relocate;
		logic  keep_fit;
		logic  walk_end;
		logic  hit;
		logic  grow_ok;
		logic  need_link;
		logic  n_valid;
		logic  merge_chk;
		logic  n_is_b;
		logic  out_free;
	} dp_stat_t;

	function automatic rec_t absorb(rec_t b, rec_t n);
		rec_t r;
		r = b;
		r.bytes = b.bytes + SIZE_BITS'(HEADER_BYTES) + n.bytes;
		r.link = n.link;
		return r;
	endfunction

endpackage

// ===== rtl/core/ffba_req_if.sv =====
interface ffba_req_if;
	logic                           valid;
	logic                           ready;
	logic [1:0]                     func;
	logic [ffba_pkg::SIZE_BITS-1:0] req_size;
	logic                           has_handle;
	logic [ffba_pkg::HANDLE_W-1:0]  handle;

	modport source (output valid, func, req_size, has_handle, handle, input ready);
	modport sink (input valid, func, req_size, has_handle, handle, output ready);
endinterface

// ===== rtl/core/ffba_rsp_if.sv =====
interface ffba_rsp_if;
	logic                           valid;
	logic                           ready;
	logic [1:0]                     status;
	logic [ffba_pkg::HANDLE_W-1:0]  result_handle;
	logic [ffba_pkg::SIZE_BITS-1:0] payload_offset;
	logic [ffba_pkg::SIZE_BITS-1:0] copy_bytes;

	modport source (output valid, status, result_handle, payload_offset, copy_bytes,
		input ready);
	modport sink (input valid, status, result_handle, payload_offset, copy_bytes,
		output ready);
endinterface

// ===== rtl/core/ffba_ram.sv =====
module ffba_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== rtl/core/ffba_ctrl.sv =====
module ffba_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	input  ffba_pkg::dp_stat_t stat,
	output ffba_pkg::dp_cmd_t  cmd
);
	import ffba_pkg::*;

	state_t state_q, state_d;
	state_t after_alloc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		after_alloc = stat.relocate ? S_RRD : S_EMIT;
		state_d = state_q;
		cmd.in_ready = 1'b0;
		cmd.op = OP_NONE;
		case (state_q)
			S_IDLE: begin
				cmd.in_ready = 1'b1;
				if (req_valid) begin
					cmd.op = OP_LOAD;
					state_d = S_DISP;
				end
			end
			S_DISP: begin
				cmd.op = OP_INIT;
				if (stat.func == FN_ALLOC || (stat.func == FN_RESIZE && !stat.has)) begin
					state_d = stat.size_zero ? S_EMIT : S_ATEST;
				end else if (stat.func == FN_FREE) begin
					state_d = stat.h_valid ? S_RRD : S_EMIT;
				end else if (stat.func == FN_RESIZE) begin
					if (!stat.h_valid) begin
						state_d = S_EMIT;
					end else begin
						state_d = stat.size_zero ? S_RRD : S_KRD;
					end
				end else begin
					state_d = S_EMIT;
				end
			end
			S_KRD: begin
				cmd.op = OP_KRD;
				state_d = S_KCHK;
			end
			S_KCHK: begin
				cmd.op = OP_KCHK;
				state_d = stat.keep_fit ? S_EMIT : S_ATEST;
			end
			S_ATEST: begin
				cmd.op = OP_ATEST;
				state_d = stat.walk_end ? S_GROW : S_AEVAL;
			end
			S_AEVAL: begin
				cmd.op = OP_AEVAL;
				state_d = stat.hit ? after_alloc : S_ATEST;
			end
			S_GROW: begin
				cmd.op = OP_GROW;
				if (!stat.grow_ok) begin
					state_d = S_EMIT;
				end else begin
					state_d = stat.need_link ? S_GLINK : after_alloc;
				end
			end
			S_GLINK: begin
				cmd.op = OP_GLINK;
				state_d = after_alloc;
			end
			S_RRD: begin
				cmd.op = OP_RRD;
				state_d = S_RMARK;
			end
			S_RMARK: begin
				cmd.op = OP_RMARK;
				state_d = stat.n_valid ? S_RNRD : S_WTEST;
			end
			S_RNRD: begin
				cmd.op = OP_RNRD;
				state_d = S_RNCHK;
			end
			S_RNCHK: begin
				cmd.op = OP_RNCHK;
				state_d = S_WTEST;
			end
			S_WTEST: begin
				cmd.op = OP_WTEST;
				state_d = stat.walk_end ? S_EMIT : S_WEVAL;
			end
			S_WEVAL: begin
				cmd.op = OP_WEVAL;
				state_d = stat.merge_chk ? S_WNEVAL : S_WTEST;
			end
			S_WNEVAL: begin
				cmd.op = OP_WNEVAL;
				state_d = stat.n_is_b ? S_EMIT : S_WTEST;
			end
			S_EMIT: begin
				cmd.op = OP_EMIT;
				if (stat.out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end
endmodule

// ===== rtl/core/ffba_dp.sv =====
module ffba_dp (
	input  logic                           clk,
	input  logic                           arst_n,
	input  ffba_pkg::dp_cmd_t              cmd,
	input  logic [ffba_pkg::SIZE_BITS-1:0] heap_limit,
	output ffba_pkg::dp_stat_t             stat,
	ffba_req_if.sink                       req,
	ffba_rsp_if.source                     rsp
);
	import ffba_pkg::*;

	localparam int GW = SIZE_BITS + 2;
	localparam logic [LINK_W-1:0] NIL = LINK_W'(MAX_BLOCKS);

	// control state
	logic                 ov_q;
	logic [LINK_W-1:0]    used_q;
	logic [LINK_W-1:0]    head_q;
	logic [SIZE_BITS:0]   heap_end_q;

	// working registers
	func_t                func_q;
	logic [SIZE_BITS-1:0] size_q;
	logic                 has_q;
	logic [IDX_W-1:0]     h_q;
	logic [LINK_W-1:0]    cur_q, last_q, n_q, nb_q, steps_q;
	rec_t                 last_rec_q, cur_rec_q, brec_q;
	status_t              st_q;
	logic [IDX_W-1:0]     rh_q;
	logic [SIZE_BITS-1:0] off_q, copy_q;
	status_t              ost_q;
	logic [IDX_W-1:0]     orh_q;
	logic [SIZE_BITS-1:0] ooff_q, ocopy_q;

	logic                 we;
	logic [IDX_W-1:0]     waddr, raddr;
	rec_t                 wrec, rd;
	logic [REC_W-1:0]     rdata;
	logic [GW-1:0]        grow_last;
	logic                 out_free;

	ffba_ram #(.WIDTH(REC_W), .DEPTH(MAX_BLOCKS)) u_rec (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wrec),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign rd = rec_t'(rdata);
	assign grow_last = GW'(heap_end_q) + GW'(HEADER_BYTES) + GW'(size_q) - GW'(1);
	assign out_free = !ov_q || rsp.ready;

	always_comb begin
		stat.func = func_q;
		stat.has = has_q;
		stat.h_valid = has_q && (LINK_W'(h_q) < used_q);
		stat.size_zero = (size_q == '0);
		stat.relocate = (func_q == FN_RESIZE) && has_q;
		stat.keep_fit = rd.bytes >= size_q;
		stat.walk_end = (cur_q >= NIL) || (steps_q > NIL);
		stat.hit = rd.free && (rd.bytes >= size_q);
		stat.grow_ok = (used_q < NIL) && (grow_last <= GW'(heap_limit));
		stat.need_link = last_q < NIL;
		stat.n_valid = rd.link < NIL;
		stat.merge_chk = rd.free && (rd.link < NIL);
		stat.n_is_b = n_q == LINK_W'(h_q);
		stat.out_free = out_free;
	end

	always_comb begin
		we = 1'b0;
		waddr = h_q;
		wrec = rd;
		raddr = h_q;
		case (cmd.op)
			OP_ATEST, OP_WTEST: begin
				raddr = cur_q[IDX_W-1:0];
			end
			OP_AEVAL: begin
				waddr = cur_q[IDX_W-1:0];
				wrec.free = 1'b0;
				we = stat.hit;
			end
			OP_GROW: begin
				we = stat.grow_ok;
				waddr = used_q[IDX_W-1:0];
				wrec.bytes = size_q;
				wrec.start = heap_end_q[SIZE_BITS-1:0];
				wrec.link = NIL;
				wrec.free = 1'b0;
			end
			OP_GLINK: begin
				we = 1'b1;
				waddr = last_q[IDX_W-1:0];
				wrec = last_rec_q;
				wrec.link = nb_q;
			end
			OP_RMARK: begin
				we = 1'b1;
				wrec.free = 1'b1;
			end
			OP_RNRD: begin
				raddr = n_q[IDX_W-1:0];
			end
			OP_RNCHK: begin
				we = rd.free;
				wrec = absorb(brec_q, rd);
			end
			OP_WEVAL: begin
				raddr = rd.link[IDX_W-1:0];
			end
			OP_WNEVAL: begin
				we = stat.n_is_b || rd.free;
				waddr = cur_q[IDX_W-1:0];
				wrec = absorb(cur_rec_q, rd);
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
			used_q <= '0;
			head_q <= NIL;
			heap_end_q <= '0;
		end else begin
			if (cmd.op == OP_EMIT && out_free) begin
				ov_q <= 1'b1;
			end else if (rsp.ready) begin
				ov_q <= 1'b0;
			end
			if (cmd.op == OP_GROW && stat.grow_ok) begin
				used_q <= used_q + LINK_W'(1);
				heap_end_q <= heap_end_q + (SIZE_BITS+1)'(HEADER_BYTES)
					+ (SIZE_BITS+1)'(size_q);
				if (!stat.need_link) begin
					head_q <= used_q;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				func_q <= func_t'(req.func);
				size_q <= req.req_size;
				has_q <= req.has_handle;
				h_q <= req.handle;
			end
			OP_INIT: begin
				st_q <= ST_NULL;
				rh_q <= '0;
				off_q <= '0;
				copy_q <= '0;
				cur_q <= head_q;
				last_q <= NIL;
				steps_q <= '0;
			end
			OP_KCHK: begin
				if (stat.keep_fit) begin
					st_q <= ST_OK;
					rh_q <= h_q;
					off_q <= rd.start + SIZE_BITS'(HEADER_BYTES);
				end else begin
					copy_q <= rd.bytes;
				end
			end
			OP_ATEST, OP_WTEST: begin
				steps_q <= steps_q + LINK_W'(1);
			end
			OP_AEVAL: begin
				if (stat.hit) begin
					st_q <= ST_OK;
					rh_q <= cur_q[IDX_W-1:0];
					off_q <= rd.start + SIZE_BITS'(HEADER_BYTES);
				end else begin
					last_q <= cur_q;
					last_rec_q <= rd;
					cur_q <= rd.link;
				end
			end
			OP_GROW: begin
				if (stat.grow_ok) begin
					st_q <= ST_OK;
					rh_q <= used_q[IDX_W-1:0];
					off_q <= heap_end_q[SIZE_BITS-1:0] + SIZE_BITS'(HEADER_BYTES);
					nb_q <= used_q;
				end else begin
					st_q <= ST_FAIL;
					rh_q <= '0;
					off_q <= '0;
					copy_q <= '0;
				end
			end
			OP_RMARK: begin
				brec_q <= wrec;
				n_q <= rd.link;
				cur_q <= head_q;
				steps_q <= '0;
			end
			OP_WEVAL: begin
				cur_rec_q <= rd;
				n_q <= rd.link;
				if (!stat.merge_chk) begin
					cur_q <= rd.link;
				end
			end
			OP_WNEVAL: begin
				if (rd.free) begin
					cur_q <= rd.link;
				end else begin
					cur_q <= n_q;
				end
			end
			OP_EMIT: begin
				if (out_free) begin
					ost_q <= st_q;
					orh_q <= rh_q;
					ooff_q <= off_q;
					ocopy_q <= copy_q;
				end
			end
			default: begin
				cur_q <= cur_q;
			end
		endcase
	end

	assign rsp.valid = ov_q;
	assign rsp.status = ost_q;
	assign rsp.result_handle = HANDLE_W'(orh_q);
	assign rsp.payload_offset = ooff_q;
	assign rsp.copy_bytes = ocopy_q;
endmodule

// ===== rtl/core/first_fit_block_allocator.sv =====
// The allocate walk tests and evaluates each list record in turn; the free walk tests and
// evaluates each record and checks its successor when a merge is possible; a resize that
// relocates runs both walks, all bound by the single read port of the block record memory.
// Throughput: one word at a time; the next word is taken while the last result waits.
// Reset (arst_n low, asynchronous): empty block list, no records used, heap end 0,
// heap_limit all ones; record memory contents are not cleared.
module first_fit_block_allocator (
	input  logic                             clk,
	input  logic                             arst_n,
	ffba_req_if.sink                         req,
	ffba_rsp_if.source                       rsp,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [ffba_pkg::CFG_ADDR_W-1:0]  paddr,
	input  logic [31:0]                      pwdata,
	output logic [31:0]                      prdata,
	output logic                             pready
);
	import ffba_pkg::*;

	`include "first_fit_block_allocator_assert.svh"

	logic [SIZE_BITS-1:0] heap_limit_q;
	dp_cmd_t              cmd;
	dp_stat_t             stat;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == CFG_HEAP_LIMIT) ? 32'(heap_limit_q) : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heap_limit_q <= '1;
		end else if (psel && penable && pwrite && pready && paddr[2] == CFG_HEAP_LIMIT) begin
			heap_limit_q <= pwdata[SIZE_BITS-1:0];
		end
	end

	ffba_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.stat      (stat),
		.cmd       (cmd)
	);

	ffba_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.heap_limit (heap_limit_q),
		.stat       (stat),
		.req        (req),
		.rsp        (rsp)
	);

	assign req.ready = cmd.in_ready;

	`FFBA_ASSERT_NEXT(a_busy_after_accept, req.valid && req.ready, !req.ready, "ready after accept")
	`FFBA_ASSERT_NEXT(a_emit_loads, cmd.op == OP_EMIT && stat.out_free, rsp.valid, "result lost")
	`FFBA_ASSERT_NOW(a_valid_from_emit, $rose(rsp.valid), $past(cmd.op == OP_EMIT), "stray word")
endmodule
